### hw/rtl/dfcp_pkg.sv
// ----------------------------------------------------------------------------
// dfcp_pkg
// Shared types, codes and decode helpers for the data frame command parser.
// ----------------------------------------------------------------------------
package dfcp_pkg;

    localparam int LINE_STORE_DEF    = 96;
    localparam int PAYLOAD_STORE_DEF = 9;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 16;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;

    // request kinds carried on s_axis_tuser
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // command codes
    localparam logic [2:0] CMD_NONE = 3'd0;
    localparam logic [2:0] CMD_A1   = 3'd1;
    localparam logic [2:0] CMD_A2   = 3'd2;
    localparam logic [2:0] CMD_A3   = 3'd3;
    localparam logic [2:0] CMD_B1   = 3'd4;
    localparam logic [2:0] CMD_B2   = 3'd5;
    localparam logic [2:0] CMD_B3   = 3'd6;

    localparam logic signed [1:0] TURN_NEG  = -2'sd1;
    localparam logic signed [1:0] TURN_ZERO = 2'sd0;
    localparam logic signed [1:0] TURN_POS  = 2'sd1;

    typedef enum logic [3:0] {
        PH_HDR0  = 4'd0,
        PH_HDR1  = 4'd1,
        PH_HDR2  = 4'd2,
        PH_HDR3  = 4'd3,
        PH_HDR4  = 4'd4,
        PH_LINK  = 4'd5,
        PH_COMMA = 4'd6,
        PH_LEN   = 4'd7,
        PH_PAY   = 4'd8,
        PH_STOP  = 4'd9,
        PH_FAIL  = 4'd10
    } phase_t;

    typedef struct packed {
        logic       done;
        logic [2:0] cmd;
    } line_res_t;

    typedef struct packed {
        logic              line_done;
        logic              cmd_accepted;
        logic              pop_valid;
        logic [2:0]        cmd_code;
        logic signed [1:0] first_turn;
        logic signed [1:0] second_turn;
        logic [2:0]        last_cmd;
    } result_t;

    // expected character for each header-search step
    function automatic logic [7:0] hdr_char(input phase_t ph);
        logic [7:0] c;
        case (ph)
            PH_HDR0: c = CH_PLUS;
            PH_HDR1: c = CH_I;
            PH_HDR2: c = CH_P;
            PH_HDR3: c = CH_D;
            PH_HDR4: c = CH_COMMA;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    // two payload chars -> command code, CMD_NONE if not a1..a3 / b1..b3
    function automatic logic [2:0] decode_cmd(input logic [7:0] c0, input logic [7:0] c1);
        logic [2:0] base;
        logic [2:0] cmd;
        base = 3'd0;
        cmd  = CMD_NONE;
        if (c0 == CH_B) begin
            base = 3'd3;
        end
        if (((c0 == CH_A) || (c0 == CH_B)) && (c1 >= CH_1) && (c1 <= CH_3)) begin
            cmd = base + 3'(c1 - CH_0);
        end
        return cmd;
    endfunction

    function automatic logic signed [1:0] turn_first(input logic [2:0] c);
        logic signed [1:0] t;
        case (c)
            CMD_A1, CMD_A2, CMD_A3: t = TURN_NEG;
            CMD_B1, CMD_B2, CMD_B3: t = TURN_POS;
            default:                t = TURN_ZERO;
        endcase
        return t;
    endfunction

    function automatic logic signed [1:0] turn_second(input logic [2:0] c);
        logic signed [1:0] t;
        case (c)
            CMD_A1, CMD_B1: t = TURN_POS;
            CMD_A3, CMD_B3: t = TURN_NEG;
            default:        t = TURN_ZERO;
        endcase
        return t;
    endfunction

endpackage

### hw/rtl/data_frame_command_parser.sv
// ----------------------------------------------------------------------------
// data_frame_command_parser
// Line-oriented "+IPD," frame parser with a one-deep pending command slot.
// ----------------------------------------------------------------------------
// Input stream: each request is either a received byte (tuser = 0, byte in
// tdata) or a pop of the pending command (tuser = 1, tdata ignored).
// Output stream: exactly one result per request, in request order.
// Lines end at LF or when the line reaches LINE_STORE-1 bytes; at line end,
// with parse_enable set, a well-formed frame carrying a1..a3 or b1..b3 sets
// the last and pending command.
// Each request passes through the input register, then the result
// register. Throughput is one request per cycle; the input register frees
// whenever the result register is empty or being taken.
// When the receiver holds m_axis_tready low, one result waits in the result
// register and one request in the input register; s_axis_tready then drops.
// Reset clears the line state, the pending slot, the last command and
// parse_enable; both stream registers come up empty and s_axis_tready is low.
// parse_enable is written through cfg_wr_en/cfg_wr_data; the user must write
// it only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module data_frame_command_parser #(
    parameter int LINE_STORE    = dfcp_pkg::LINE_STORE_DEF,
    parameter int PAYLOAD_STORE = dfcp_pkg::PAYLOAD_STORE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [dfcp_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [7:0] rx_byte
    input  logic [dfcp_pkg::S_TUSER_W-1:0] s_axis_tuser,  // [0] func
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] line_done, [1] cmd_accepted, [2] pop_valid, [5:3] cmd_code,
    // [7:6] first_turn, [9:8] second_turn, [12:10] last_cmd, [15:13] zero
    output logic [dfcp_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    logic                           parse_enable_reg;
    logic                           in_valid_reg, in_valid_next;
    logic                           in_func_reg;
    logic [7:0]                     in_byte_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [dfcp_pkg::M_TDATA_W-1:0] out_data_reg;

    logic                s_accept;
    logic                proc;
    dfcp_pkg::line_res_t line_res;
    dfcp_pkg::result_t   result;

    always_comb begin
        proc           = in_valid_reg && (!out_valid_reg || m_axis_tready);
        s_axis_tready  = aresetn && (!in_valid_reg || proc);
        s_accept       = s_axis_tvalid && s_axis_tready;
        in_valid_next  = s_accept ? 1'b1 : (proc ? 1'b0 : in_valid_reg);
        out_valid_next = proc ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    dfcp_line_parser #(
        .LINE_STORE   (LINE_STORE),
        .PAYLOAD_STORE(PAYLOAD_STORE)
    ) u_line_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (proc && (in_func_reg == dfcp_pkg::FUNC_BYTE)),
        .rx_byte     (in_byte_reg),
        .parse_enable(parse_enable_reg),
        .line_res    (line_res)
    );

    dfcp_cmd_slot u_cmd_slot (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (proc),
        .func    (in_func_reg),
        .line_res(line_res),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_enable_reg <= 1'b0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                parse_enable_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_func_reg <= s_axis_tuser[0];
            in_byte_reg <= s_axis_tdata[7:0];
        end
        if (proc) begin
            out_data_reg <= {3'd0, result.last_cmd, result.second_turn, result.first_turn,
                             result.cmd_code, result.pop_valid, result.cmd_accepted,
                             result.line_done};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // a result is either a line result or a pop, never both
    a_kind_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[2]))
        else $error("line_done and pop_valid both set");

    // an accepted command ends a line and becomes the last command
    a_accept_updates_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[1]) |->
            (m_axis_tdata[0] && (m_axis_tdata[12:10] == m_axis_tdata[5:3])))
        else $error("accepted command not reflected in last_cmd");

    // backpressure only when both stages are full
    a_ready_low_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled with free stage");

    // a request held in the input register is not dropped
    a_in_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !proc) |=> in_valid_reg)
        else $error("pending request lost");

endmodule

### hw/rtl/dfcp_line_parser.sv
// ----------------------------------------------------------------------------
// dfcp_line_parser
// Per-byte frame tracker: header search, link/length fields, payload capture,
// line end detection and command recognition at line end.
// ----------------------------------------------------------------------------
module dfcp_line_parser #(
    parameter int LINE_STORE    = dfcp_pkg::LINE_STORE_DEF,
    parameter int PAYLOAD_STORE = dfcp_pkg::PAYLOAD_STORE_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic [7:0]          rx_byte,
    input  logic                parse_enable,
    output dfcp_pkg::line_res_t line_res
);

    localparam int LC_W = $clog2(LINE_STORE);
    localparam int PC_W = $clog2(PAYLOAD_STORE);

    dfcp_pkg::phase_t phase_reg, phase_next;
    logic [LC_W-1:0]  line_count_reg, line_count_next;
    logic [15:0]      len_reg, len_next;
    logic             len_seen_reg, len_seen_next;
    logic [PC_W-1:0]  pay_count_reg, pay_count_next;
    logic [15:0]      pay_head_reg, pay_head_next;

    logic [LC_W:0]    count_inc;
    logic             digit;
    logic             pay_stop;
    logic             line_end;
    logic [2:0]       cmd_found;

    always_comb begin
        digit     = dfcp_pkg::is_digit(rx_byte);
        count_inc = {1'b0, line_count_reg} + (LC_W+1)'(1);
        line_end  = (rx_byte == dfcp_pkg::CH_LF) || (count_inc >= (LC_W+1)'(LINE_STORE - 1));
        pay_stop  = ({{(16-PC_W){1'b0}}, pay_count_reg} >= len_reg) ||
                    (pay_count_reg >= PC_W'(PAYLOAD_STORE - 1)) ||
                    (rx_byte == dfcp_pkg::CH_CR) || (rx_byte == dfcp_pkg::CH_LF) ||
                    (rx_byte == dfcp_pkg::CH_NUL);

        phase_next     = phase_reg;
        len_next       = len_reg;
        len_seen_next  = len_seen_reg;
        pay_count_next = pay_count_reg;
        pay_head_next  = pay_head_reg;

        case (phase_reg)
            dfcp_pkg::PH_HDR0, dfcp_pkg::PH_HDR1, dfcp_pkg::PH_HDR2,
            dfcp_pkg::PH_HDR3, dfcp_pkg::PH_HDR4: begin
                if (rx_byte == dfcp_pkg::hdr_char(phase_reg)) begin
                    phase_next = dfcp_pkg::phase_t'(phase_reg + 4'd1);
                end else if (rx_byte == dfcp_pkg::CH_PLUS) begin
                    phase_next = dfcp_pkg::PH_HDR1;
                end else begin
                    phase_next = dfcp_pkg::PH_HDR0;
                end
            end
            dfcp_pkg::PH_LINK: begin
                phase_next = digit ? dfcp_pkg::PH_COMMA : dfcp_pkg::PH_FAIL;
            end
            dfcp_pkg::PH_COMMA: begin
                phase_next = (rx_byte == dfcp_pkg::CH_COMMA) ? dfcp_pkg::PH_LEN
                                                             : dfcp_pkg::PH_FAIL;
            end
            dfcp_pkg::PH_LEN: begin
                if (digit) begin
                    // len * 10 + digit, wraps at 16 bits
                    len_next      = 16'((len_reg << 3) + (len_reg << 1) +
                                        {8'd0, 8'(rx_byte - dfcp_pkg::CH_0)});
                    len_seen_next = 1'b1;
                end else if ((rx_byte == dfcp_pkg::CH_COLON) && len_seen_reg) begin
                    phase_next = dfcp_pkg::PH_PAY;
                end else begin
                    phase_next = dfcp_pkg::PH_FAIL;
                end
            end
            dfcp_pkg::PH_PAY: begin
                if (pay_stop) begin
                    phase_next = dfcp_pkg::PH_STOP;
                end else begin
                    if (pay_count_reg == '0) begin
                        pay_head_next = {8'd0, rx_byte};
                    end else if (pay_count_reg == PC_W'(1)) begin
                        pay_head_next = {rx_byte, pay_head_reg[7:0]};
                    end
                    pay_count_next = pay_count_reg + PC_W'(1);
                end
            end
            default: begin
            end
        endcase

        cmd_found = dfcp_pkg::CMD_NONE;
        if (((phase_next == dfcp_pkg::PH_PAY) || (phase_next == dfcp_pkg::PH_STOP)) &&
            (pay_count_next == PC_W'(2))) begin
            cmd_found = dfcp_pkg::decode_cmd(pay_head_next[7:0], pay_head_next[15:8]);
        end

        line_res.done = line_end;
        line_res.cmd  = (line_end && parse_enable) ? cmd_found : dfcp_pkg::CMD_NONE;

        line_count_next = count_inc[LC_W-1:0];
        if (line_end) begin
            phase_next      = dfcp_pkg::PH_HDR0;
            line_count_next = '0;
            len_next        = '0;
            len_seen_next   = 1'b0;
            pay_count_next  = '0;
            pay_head_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= dfcp_pkg::PH_HDR0;
            line_count_reg <= '0;
            len_reg        <= '0;
            len_seen_reg   <= 1'b0;
            pay_count_reg  <= '0;
            pay_head_reg   <= '0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            line_count_reg <= line_count_next;
            len_reg        <= len_next;
            len_seen_reg   <= len_seen_next;
            pay_count_reg  <= pay_count_next;
            pay_head_reg   <= pay_head_next;
        end
    end

endmodule

### hw/rtl/dfcp_cmd_slot.sv
// ----------------------------------------------------------------------------
// dfcp_cmd_slot
// One-deep pending command slot plus last-command register; builds the
// result for each request including the turn decode.
// ----------------------------------------------------------------------------
module dfcp_cmd_slot (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic                func,
    input  dfcp_pkg::line_res_t line_res,
    output dfcp_pkg::result_t   result
);

    logic       pend_flag_reg, pend_flag_next;
    logic [2:0] pend_cmd_reg, pend_cmd_next;
    logic [2:0] recent_cmd_reg, recent_cmd_next;
    logic [2:0] code;

    always_comb begin
        pend_flag_next  = pend_flag_reg;
        pend_cmd_next   = pend_cmd_reg;
        recent_cmd_next = recent_cmd_reg;
        code            = dfcp_pkg::CMD_NONE;

        result.line_done    = 1'b0;
        result.cmd_accepted = 1'b0;
        result.pop_valid    = 1'b0;

        if (func == dfcp_pkg::FUNC_POP) begin
            if (pend_flag_reg) begin
                result.pop_valid = 1'b1;
                code             = pend_cmd_reg;
                pend_flag_next   = 1'b0;
            end
        end else begin
            result.line_done = line_res.done;
            code             = line_res.cmd;
            if (line_res.cmd != dfcp_pkg::CMD_NONE) begin
                result.cmd_accepted = 1'b1;
                recent_cmd_next     = line_res.cmd;
                pend_cmd_next       = line_res.cmd;
                pend_flag_next      = 1'b1;
            end
        end

        result.cmd_code    = code;
        result.first_turn  = dfcp_pkg::turn_first(code);
        result.second_turn = dfcp_pkg::turn_second(code);
        result.last_cmd    = recent_cmd_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_flag_reg  <= 1'b0;
            pend_cmd_reg   <= dfcp_pkg::CMD_NONE;
            recent_cmd_reg <= dfcp_pkg::CMD_NONE;
        end else if (step_en) begin
            pend_flag_reg  <= pend_flag_next;
            pend_cmd_reg   <= pend_cmd_next;
            recent_cmd_reg <= recent_cmd_next;
        end
    end

endmodule
